FILE: design/atlas_first_fit_rect_allocator_defines.svh
`ifndef ATLAS_FIRST_FIT_RECT_ALLOCATOR_DEFINES_SVH
`define ATLAS_FIRST_FIT_RECT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define AFFRA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("affra check failed");

// Next-cycle implication, checked on clk, off during reset.
`define AFFRA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("affra check failed");

`endif

FILE: design/affra_pkg.sv
`default_nettype none
package affra_pkg;
	localparam int GRID_CELLS   = 1024;
	localparam int CELL_PIXELS  = 4;
	localparam int MARGIN_CELLS = 2;
	localparam int CELL_W       = $clog2(GRID_CELLS);
	localparam int LIM_W        = 14;

	typedef struct packed {
		logic [12:0] width_px;
		logic [12:0] height_px;
	} req_t;

	typedef struct packed {
		logic [11:0] place_x_px;
		logic [11:0] place_y_px;
		logic        fitted;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_ACC,
		ST_SCAN,
		ST_MASK,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

FILE: design/atlas_first_fit_rect_allocator.sv
`default_nettype none
// First-fit rectangle allocator over a 1024 x 1024 occupancy bitmap of 4-pixel cells.
// Request channel: drive req and pulse start; a transfer happens at a clock edge
// with start high and busy low. busy stays high until the result is shown.
// Result channel: done is high for exactly one cycle with res valid; the receiver
// cannot stall, so the result must be taken in that cycle.
// Each column word of the bitmap sits in one memory row. For every candidate
// column x the columns x..x+wc are read and ORed one at a time, then the
// rows are scanned one bit a cycle for a free run of hc+1 rows.
// After the search a row mask is built one row bit a cycle, then every marked
// column is read and written back, and then the result is shown.
// The single memory port and the one-bit row scan make each of these steps serial.
// After reset the block runs a clearing pass over all 1024 column words (one
// column word a cycle) with busy high, and then accepts requests.
module atlas_first_fit_rect_allocator
	import affra_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  req_t      req,
	output logic      done,
	output res_t      res
);
	state_t state_q, state_d;
	logic [CELL_W:0]   col_q, col_d;
	logic [CELL_W-1:0] x_q, x_d, k_q, k_d, y_q, y_d, px_q, px_d, py_q, py_d;
	logic [CELL_W:0]   run_q, run_d;
	logic [11:0]       wc_q, wc_d, hc_q, hc_d;
	logic              fit_q, fit_d;
	logic [GRID_CELLS-1:0] vec_q, vec_d, rd_q, wd;
	logic [CELL_W-1:0] ra, wa;
	logic              we;
	logic [GRID_CELLS-1:0] mem [GRID_CELLS];

	logic [11:0] wc_in, hc_in;
	logic [LIM_W-1:0] x_lo, x_hi, y_lo, y_hi, x_hi_raw, y_hi_raw;

	assign wc_in = 12'(({1'b0, req.width_px} + 14'(CELL_PIXELS - 1)) / 14'(CELL_PIXELS));
	assign hc_in = 12'(({1'b0, req.height_px} + 14'(CELL_PIXELS - 1)) / 14'(CELL_PIXELS));

	assign x_lo = (LIM_W'(px_q) >= LIM_W'(MARGIN_CELLS)) ?
		LIM_W'(px_q) - LIM_W'(MARGIN_CELLS) : '0;
	assign y_lo = (LIM_W'(py_q) >= LIM_W'(MARGIN_CELLS)) ?
		LIM_W'(py_q) - LIM_W'(MARGIN_CELLS) : '0;
	assign x_hi_raw = LIM_W'(px_q) + LIM_W'(wc_q) + LIM_W'(MARGIN_CELLS);
	assign y_hi_raw = LIM_W'(py_q) + LIM_W'(hc_q) + LIM_W'(MARGIN_CELLS);
	assign x_hi = (x_hi_raw > LIM_W'(GRID_CELLS)) ? LIM_W'(GRID_CELLS) : x_hi_raw;
	assign y_hi = (y_hi_raw > LIM_W'(GRID_CELLS)) ? LIM_W'(GRID_CELLS) : y_hi_raw;

	always_comb begin
		state_d = state_q;
		col_d   = col_q;
		x_d     = x_q;
		k_d     = k_q;
		y_d     = y_q;
		run_d   = run_q;
		wc_d    = wc_q;
		hc_d    = hc_q;
		px_d    = px_q;
		py_d    = py_q;
		fit_d   = fit_q;
		vec_d   = vec_q;
		ra      = '0;
		wa      = col_q[CELL_W-1:0];
		we      = 1'b0;
		wd      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				col_d = col_q + 1'b1;
				if (col_q == (CELL_W+1)'(GRID_CELLS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					wc_d = wc_in;
					hc_d = hc_in;
					if (wc_in < 12'(GRID_CELLS) && hc_in < 12'(GRID_CELLS)) begin
						x_d = '0;
						k_d = '0;
						vec_d = '0;
						state_d = ST_RD;
					end else begin
						px_d = '0;
						py_d = '0;
						fit_d = 1'b0;
						col_d = '0;
						state_d = ST_MASK;
					end
				end
			end
			ST_RD: begin
				ra = x_q + k_q;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				vec_d = vec_q | rd_q;
				if (k_q == wc_q[CELL_W-1:0]) begin
					y_d = '0;
					run_d = '0;
					state_d = ST_SCAN;
				end else begin
					k_d = k_q + 1'b1;
					state_d = ST_RD;
				end
			end
			ST_SCAN: begin
				vec_d = vec_q >> 1;
				if (!vec_q[0] && 12'(run_q) == hc_q) begin
					px_d = x_q;
					py_d = y_q - hc_q[CELL_W-1:0];
					fit_d = 1'b1;
					col_d = '0;
					state_d = ST_MASK;
				end else begin
					run_d = vec_q[0] ? '0 : run_q + 1'b1;
					y_d = y_q + 1'b1;
					if (y_q == CELL_W'(GRID_CELLS - 1)) begin
						// column exhausted: advance x or give up
						if (LIM_W'(x_q) + LIM_W'(1) + LIM_W'(wc_q) < LIM_W'(GRID_CELLS)) begin
							x_d = x_q + 1'b1;
							k_d = '0;
							vec_d = '0;
							state_d = ST_RD;
						end else begin
							px_d = '0;
							py_d = '0;
							fit_d = 1'b0;
							col_d = '0;
							state_d = ST_MASK;
						end
					end
				end
			end
			ST_MASK: begin
				// shift in row bits from the top; the first lands at row 0
				vec_d = {(LIM_W'(col_q) >= y_lo) && (LIM_W'(col_q) < y_hi),
					vec_q[GRID_CELLS-1:1]};
				col_d = col_q + 1'b1;
				if (col_q == (CELL_W+1)'(GRID_CELLS - 1)) begin
					col_d = (CELL_W+1)'(x_lo);
					state_d = (x_lo < x_hi) ? ST_MARK_RD : ST_DONE;
				end
			end
			ST_MARK_RD: begin
				ra = col_q[CELL_W-1:0];
				state_d = ST_MARK_WR;
			end
			ST_MARK_WR: begin
				we = 1'b1;
				wd = rd_q | vec_q;
				col_d = col_q + 1'b1;
				state_d = (LIM_W'(col_q) + LIM_W'(1) == x_hi) ? ST_DONE : ST_MARK_RD;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			col_q   <= '0;
			x_q     <= '0;
			k_q     <= '0;
			y_q     <= '0;
			run_q   <= '0;
			wc_q    <= '0;
			hc_q    <= '0;
			px_q    <= '0;
			py_q    <= '0;
			fit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			x_q     <= x_d;
			k_q     <= k_d;
			y_q     <= y_d;
			run_q   <= run_d;
			wc_q    <= wc_d;
			hc_q    <= hc_d;
			px_q    <= px_d;
			py_q    <= py_d;
			fit_q   <= fit_d;
		end
	end

	always_ff @(posedge clk) begin
		vec_q <= vec_d;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res.place_x_px = 12'(px_q * CELL_PIXELS);
	assign res.place_y_px = 12'(py_q * CELL_PIXELS);
	assign res.fitted     = fit_q;
endmodule
`default_nettype wire

FILE: design/affra_checker.sv
`default_nettype none
`include "atlas_first_fit_rect_allocator_defines.svh"
module affra_checker
	import affra_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire res_t res
);
	`AFFRA_ASSERT_NOW(a_done_busy, done, busy)
	`AFFRA_ASSERT_NEXT(a_xfer_busy, start && !busy, busy)
	`AFFRA_ASSERT_NEXT(a_done_pulse, done, !done && !busy)
	`AFFRA_ASSERT_NOW(a_nofit_origin, done && !res.fitted,
		res.place_x_px == 12'd0 && res.place_y_px == 12'd0)
endmodule

bind atlas_first_fit_rect_allocator affra_checker u_affra_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.res(res)
);
`default_nettype wire
